/* design/pnf_pkg.sv */
// Package for the pink noise filter: widths, sequencer codes, coefficient table, saturation.
package pnf_pkg;

    localparam int SAMPLE_WIDTH = 24;
    localparam int STATE_WIDTH  = 32;
    localparam int WHITE_WIDTH  = SAMPLE_WIDTH + 1;
    localparam int COEF_WIDTH   = 21;
    localparam int COEF_FRAC    = 20;
    localparam int PROD_WIDTH   = STATE_WIDTH + COEF_WIDTH;
    localparam int RND_WIDTH    = PROD_WIDTH - COEF_FRAC;
    localparam int STAGE_SUM_W  = STATE_WIDTH + 2;
    localparam int SUM_WIDTH    = STATE_WIDTH + 4;
    localparam int N_STAGES     = 7;

    typedef logic [3:0] t_op;

    localparam t_op OP_DIRECT = 4'd12;
    localparam t_op OP_DELAY  = 4'd13;
    localparam t_op OP_GAIN   = 4'd14;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DONE
    } t_state;

    // even ops below twelve: leak of stage op/2, odd ops below twelve: white feed of stage op/2
    function automatic logic signed [COEF_WIDTH-1:0] coef_of(input t_op op);
        logic signed [COEF_WIDTH-1:0] c;
        case (op)
            4'd0:      c = 21'sd1047381;
            4'd1:      c = 21'sd58215;
            4'd2:      c = 21'sd1041572;
            4'd3:      c = 21'sd78723;
            4'd4:      c = 21'sd1016070;
            4'd5:      c = 21'sd161326;
            4'd6:      c = 21'sd908591;
            4'd7:      c = 21'sd325568;
            4'd8:      c = 21'sd576717;
            4'd9:      c = 21'sd558841;
            4'd10:     c = -21'sd798595;
            4'd11:     c = -21'sd17719;
            OP_DIRECT: c = 21'sd562246;
            OP_DELAY:  c = 21'sd121557;
            OP_GAIN:   c = 21'sd115343;
            default:   c = '0;
        endcase
        return c;
    endfunction

    function automatic logic signed [STATE_WIDTH-1:0] sat_stage(
        input logic signed [STAGE_SUM_W-1:0] v
    );
        logic signed [STAGE_SUM_W-1:0] hi;
        logic signed [STAGE_SUM_W-1:0] lo;
        hi = STAGE_SUM_W'((64'sd1 <<< (STATE_WIDTH - 1)) - 64'sd1);
        lo = -hi - STAGE_SUM_W'(1);
        if (v > hi) return hi[STATE_WIDTH-1:0];
        if (v < lo) return lo[STATE_WIDTH-1:0];
        return v[STATE_WIDTH-1:0];
    endfunction

    function automatic logic signed [STATE_WIDTH-1:0] sat_sum(
        input logic signed [SUM_WIDTH-1:0] v
    );
        logic signed [SUM_WIDTH-1:0] hi;
        logic signed [SUM_WIDTH-1:0] lo;
        hi = SUM_WIDTH'((64'sd1 <<< (STATE_WIDTH - 1)) - 64'sd1);
        lo = -hi - SUM_WIDTH'(1);
        if (v > hi) return hi[STATE_WIDTH-1:0];
        if (v < lo) return lo[STATE_WIDTH-1:0];
        return v[STATE_WIDTH-1:0];
    endfunction

    function automatic logic signed [SAMPLE_WIDTH-1:0] sat_sample(
        input logic signed [RND_WIDTH-1:0] v
    );
        logic signed [RND_WIDTH-1:0] hi;
        logic signed [RND_WIDTH-1:0] lo;
        hi = RND_WIDTH'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
        lo = -hi - RND_WIDTH'(1);
        if (v > hi) return hi[SAMPLE_WIDTH-1:0];
        if (v < lo) return lo[SAMPLE_WIDTH-1:0];
        return v[SAMPLE_WIDTH-1:0];
    endfunction

endpackage

/* design/pink_noise_filter.sv */
// White / refined seven-stage pink noise generator on one shared multiplier.
//
// Input stream: s_tdata carries a 24-bit uniform random word, s_tuser the
// noise kind (0 white, 1 pink). Output stream: m_tdata carries a signed
// Q1.23 sample. Every input word gives exactly one output word.
// White words skip the filter and go from the done state to the output register.
// Pink words run fifteen constant multiplies through one 32 x 21 bit
// multiplier, one per cycle, with a round and write-back stage behind
// it, then pass the done state on their way to the output register.
// s_tready is high only while no word is being worked on, so a new word
// is taken only after the previous one has left the done state.
// The output register parts the two sides: a new word is accepted while
// the previous result still waits. A finished result waits inside until
// the output register is free, and no further word is taken meanwhile.
// Reset clears the seven filter stages to zero and empties the output.
module pink_noise_filter (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [pnf_pkg::SAMPLE_WIDTH-1:0] i_s_tdata,  // [23:0] random_word
    input  logic                            i_s_tuser,  // [0] noise_kind
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [pnf_pkg::SAMPLE_WIDTH-1:0] o_m_tdata   // [23:0] noise_sample
);
    import pnf_pkg::*;

    t_state r_state, n_state;
    t_op    r_cnt;
    t_op    r_wb_op;
    logic   r_wb_en;

    logic signed [STATE_WIDTH-1:0]  r_stage [N_STAGES];
    logic signed [WHITE_WIDTH-1:0]  r_white;
    logic signed [SUM_WIDTH-1:0]    r_sum;
    logic signed [RND_WIDTH-1:0]    r_leak;
    logic signed [PROD_WIDTH-1:0]   r_prod;
    logic signed [SAMPLE_WIDTH-1:0] r_res;
    logic signed [SAMPLE_WIDTH-1:0] r_out_data;
    logic                           r_out_valid;

    logic                           s_acc;
    logic                           m_acc;
    logic                           load_out;
    logic signed [STATE_WIDTH-1:0]  mul_a;
    logic signed [COEF_WIDTH-1:0]   mul_b;
    logic signed [PROD_WIDTH-1:0]   rnd_q;
    logic signed [RND_WIDTH-1:0]    rnd;
    logic signed [STATE_WIDTH-1:0]  stage_new;

    assign s_acc      = i_s_tvalid && o_s_tready;
    assign m_acc      = r_out_valid && i_m_tready;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_s_tready = 1'b0;
        load_out   = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    n_state = i_s_tuser ? S_RUN : S_DONE;
                end
            end
            S_RUN: begin
                if (r_cnt == OP_GAIN + t_op'(1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_m_tready) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // operand select for the shared multiplier
    always_comb begin
        mul_b = coef_of(r_cnt);
        if (r_cnt < OP_DIRECT && !r_cnt[0]) begin
            mul_a = r_stage[r_cnt[3:1]];
        end else if (r_cnt == OP_GAIN) begin
            mul_a = sat_sum(r_sum);
        end else begin
            mul_a = STATE_WIDTH'(r_white);
        end
    end

    // round half up: 20 fraction bits, 21 for the output gain
    always_comb begin
        if (r_wb_op == OP_GAIN) begin
            rnd_q = r_prod + PROD_WIDTH'(64'sd1 <<< COEF_FRAC);
            rnd   = {rnd_q[PROD_WIDTH-1], rnd_q[PROD_WIDTH-1:COEF_FRAC+1]};
        end else begin
            rnd_q = r_prod + PROD_WIDTH'(64'sd1 <<< (COEF_FRAC - 1));
            rnd   = rnd_q[PROD_WIDTH-1:COEF_FRAC];
        end
        stage_new = sat_stage(STAGE_SUM_W'(r_leak) + STAGE_SUM_W'(rnd));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_wb_en <= 1'b0;
            for (int i = 0; i < N_STAGES; i++) begin
                r_stage[i] <= '0;
            end
        end else begin
            r_wb_en <= (r_state == S_RUN) && (r_cnt <= OP_GAIN);
            if (s_acc) begin
                r_cnt <= '0;
            end else if (r_state == S_RUN) begin
                r_cnt <= r_cnt + t_op'(1);
            end
            if (r_wb_en && r_wb_op < OP_DIRECT && r_wb_op[0]) begin
                r_stage[r_wb_op[3:1]] <= stage_new;
            end
            if (r_wb_en && r_wb_op == OP_DELAY) begin
                r_stage[N_STAGES-1] <= sat_stage(STAGE_SUM_W'(rnd));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod  <= mul_a * mul_b;
        r_wb_op <= r_cnt;
        if (s_acc) begin
            r_white <= {~i_s_tdata[SAMPLE_WIDTH-1], i_s_tdata[SAMPLE_WIDTH-2:0], 1'b0};
            r_res   <= {~i_s_tdata[SAMPLE_WIDTH-1], i_s_tdata[SAMPLE_WIDTH-2:0]};
            r_sum   <= '0;
        end else if (r_wb_en) begin
            if (r_wb_op < OP_DIRECT && !r_wb_op[0]) begin
                r_leak <= rnd;
            end else if (r_wb_op < OP_DIRECT) begin
                r_sum <= r_sum + SUM_WIDTH'(stage_new);
            end else if (r_wb_op == OP_DIRECT) begin
                r_sum <= r_sum + SUM_WIDTH'(rnd) + SUM_WIDTH'(r_stage[N_STAGES-1]);
            end else if (r_wb_op == OP_GAIN) begin
                r_res <= sat_sample(rnd);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (m_acc) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_data <= r_res;
        end
    end

    a_white_bypass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc && !i_s_tuser |=> r_state == S_DONE)
        else $error("white word entered the filter sequence");

    a_pink_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc && i_s_tuser |=> r_state == S_RUN && r_cnt == '0)
        else $error("pink word did not start the sequence at step zero");

    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_IDLE |-> !o_s_tready)
        else $error("input taken while a word is in progress");

    a_wb_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wb_en |-> r_state == S_RUN)
        else $error("write-back outside the filter sequence");

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |=> o_m_tvalid && $past(r_state) == S_DONE)
        else $error("output loaded outside the done state");

endmodule
